[hdl/tera_pkg.sv]
// ----------------------------------------------------------------------------
// tera_pkg
// Shared types and codes for the typed extent range allocator.
// ----------------------------------------------------------------------------
package tera_pkg;

  localparam int DefaultDepth = 64;
  localparam int AddrWidth    = 64;
  localparam int KindWidth    = 4;
  localparam int AlignWidth   = 33;
  localparam int DivSteps     = 64;

  typedef enum logic [1:0] {
    CMD_FREE   = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOFIT   = 2'd3
  } status_t;

  localparam logic [KindWidth-1:0] KindNone = '0;

  // One table entry
  typedef struct packed {
    logic [AddrWidth-1:0] start;
    logic [AddrWidth-1:0] len;
    logic [KindWidth-1:0] kind;
  } ent_t;

endpackage

[hdl/typed_extent_range_allocator_unit.sv]
// ----------------------------------------------------------------------------
// typed_extent_range_allocator_unit
// Sorted table of typed address extents with free, alloc and insert commands.
// ----------------------------------------------------------------------------
// item_stall stays high from the moment a command beat is taken until its
// result is loaded into the output register. The table lives in one
// single-port-write, registered-read memory; a command walks the table and
// shifts entries on an insert or removal, and every scan or shift step
// reads one entry and then evaluates or writes it in a separate state; an
// aligned alloc also runs the bit-serial remainder unit. A finished result
// waits in an output register, so the next command beat can be taken while
// it is still pending. After reset the block writes the initial untyped extent.
module typed_extent_range_allocator_unit
  import tera_pkg::*;
#(
  parameter int DEPTH = DefaultDepth
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [1:0]            command,
  input  logic [AddrWidth-1:0]  base_address,
  input  logic [AddrWidth-1:0]  length,
  input  logic [KindWidth-1:0]  region_kind,
  input  logic [AlignWidth-1:0] alignment,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [1:0]            status,
  output logic [AddrWidth-1:0]  granted_address
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(DivSteps + 1);

  typedef enum logic [21:0] {
    S_INIT    = 22'd1 << 0,
    S_IDLE    = 22'd1 << 1,
    S_F_START = 22'd1 << 2,
    S_F_RD    = 22'd1 << 3,
    S_F_EV    = 22'd1 << 4,
    S_F_DEC   = 22'd1 << 5,
    S_F_MRG2  = 22'd1 << 6,
    S_F_SHUP  = 22'd1 << 7,
    S_F_SHUPW = 22'd1 << 8,
    S_DROP    = 22'd1 << 9,
    S_DROPW   = 22'd1 << 10,
    S_F_RET   = 22'd1 << 11,
    S_A_RD    = 22'd1 << 12,
    S_A_EV    = 22'd1 << 13,
    S_A_DSET  = 22'd1 << 14,
    S_A_DIV   = 22'd1 << 15,
    S_A_FIT   = 22'd1 << 16,
    S_A_CUT   = 22'd1 << 17,
    S_A_REM   = 22'd1 << 18,
    S_A_OK    = 22'd1 << 19,
    S_A_FAIL  = 22'd1 << 20,
    S_DONE    = 22'd1 << 21
  } state_t;

  typedef enum logic [1:0] {
    FC_CMD   = 2'd0,
    FC_AREM  = 2'd1,
    FC_ITYP  = 2'd2,
    FC_IUNDO = 2'd3
  } fctx_t;

  state_t state;

  // Latched command
  cmd_t                  cmd;
  logic [AddrWidth-1:0]  addr;
  logic [AddrWidth-1:0]  len;
  logic [KindWidth-1:0]  kind;
  logic [KindWidth-1:0]  akind;
  logic [AlignWidth-1:0] al;

  // Table
  ent_t            mem [DEPTH];
  ent_t            rd;
  logic [IW-1:0]   count;
  logic [IW-1:0]   j;
  logic [IW-1:0]   sh;

  // Free walk
  logic [AddrWidth-1:0] fa, fs, mlen;
  logic [KindWidth-1:0] fk;
  fctx_t                fctx;
  status_t              fst, sv_st;
  ent_t                 prv, nxt;
  logic                 hp, hn, mrg_next, dctx_alloc;

  // Alloc walk
  ent_t                  cur;
  logic [AddrWidth-1:0]  aa, cend, fd;
  logic [AddrWidth-1:0]  tq, dq;
  logic [AlignWidth-1:0] rem;
  logic [SW-1:0]         dcnt;

  // Result
  status_t              res_st;
  logic [AddrWidth-1:0] res_got;

  // Memory control
  logic          we;
  logic [AW-1:0] wa, ra;
  ent_t          wd;

  // Combinational helpers
  logic [AddrWidth-1:0] pend, fend, diff, lmsub, nl;
  logic [AlignWidth:0]  rs;
  logic                 ovl, mprev, mnext;

  assign item_stall = (state != S_IDLE);

  assign pend  = prv.start + prv.len;
  assign fend  = fa + fs;
  assign ovl   = (hp && (pend > fa)) || (hn && (fend > nxt.start));
  assign mprev = hp && (prv.kind == fk) && (pend == fa);
  assign mnext = hn && (nxt.kind == fk) && (fend == nxt.start);
  assign diff  = addr - rd.start;
  assign lmsub = rd.len - len;
  assign nl    = fd - len;
  assign rs    = {rem, dq[AddrWidth-1]};

  // Drive memory ports
  always_comb begin
    we = 1'b0;
    wa = j[AW-1:0];
    wd = '0;
    ra = j[AW-1:0];
    unique case (state)
      S_INIT: begin
        we = 1'b1;
        wa = '0;
        wd = '{start: '0, len: '1, kind: KindNone};
      end
      S_F_DEC: begin
        we = (!ovl) && mprev;
        wa = AW'(j - IW'(1));
        wd = '{start: prv.start, len: prv.len + fs, kind: prv.kind};
        if (!ovl && !mprev && mnext) begin
          we = 1'b1;
          wa = j[AW-1:0];
          wd = '{start: nxt.start - fs, len: nxt.len + fs, kind: nxt.kind};
        end
      end
      S_F_MRG2: begin
        we = 1'b1;
        wa = AW'(j - IW'(1));
        wd = '{start: prv.start, len: mlen + nxt.len, kind: prv.kind};
      end
      S_F_SHUP: begin
        we = (sh == j);
        wa = j[AW-1:0];
        wd = '{start: fa, len: fs, kind: fk};
        ra = AW'(sh - IW'(1));
      end
      S_F_SHUPW: begin
        we = 1'b1;
        wa = sh[AW-1:0];
        wd = rd;
      end
      S_DROP: begin
        ra = AW'(sh + IW'(1));
      end
      S_DROPW: begin
        we = 1'b1;
        wa = sh[AW-1:0];
        wd = rd;
      end
      S_A_CUT: begin
        we = (nl != '0);
        wa = j[AW-1:0];
        wd = '{start: aa + len, len: nl, kind: cur.kind};
      end
      default: begin
      end
    endcase
  end

  // Table memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      count        <= IW'(1);
      result_valid <= 1'b0;
    end else begin
      // drop a taken result beat unless a new one is loaded now
      if (result_valid && !result_stall && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (item_valid) begin
            cmd   <= cmd_t'(command);
            addr  <= base_address;
            len   <= length;
            kind  <= region_kind;
            akind <= (cmd_t'(command) == CMD_INSERT) ? KindNone : region_kind;
            al    <= (cmd_t'(command) == CMD_INSERT) ? '0 : alignment;
            fa    <= base_address;
            fs    <= length;
            fk    <= region_kind;
            fctx  <= FC_CMD;
            j     <= '0;
            res_st  <= ST_OK;
            res_got <= '0;
            unique case (cmd_t'(command))
              CMD_FREE:   state <= S_F_START;
              CMD_ALLOC:  state <= S_A_RD;
              CMD_INSERT: state <= (region_kind == KindNone) ? S_DONE : S_A_RD;
              default:    state <= S_DONE;
            endcase
          end
        end
        // ---------------- free ----------------
        S_F_START: begin
          j  <= '0;
          hp <= 1'b0;
          hn <= 1'b0;
          if (fs == '0) begin
            fst   <= ST_OK;
            state <= S_F_RET;
          end else begin
            state <= S_F_RD;
          end
        end
        S_F_RD: begin
          state <= (j == count) ? S_F_DEC : S_F_EV;
        end
        S_F_EV: begin
          if (rd.start <= fa) begin
            prv   <= rd;
            hp    <= 1'b1;
            j     <= j + IW'(1);
            state <= S_F_RD;
          end else begin
            nxt   <= rd;
            hn    <= 1'b1;
            state <= S_F_DEC;
          end
        end
        S_F_DEC: begin
          mlen <= prv.len + fs;
          if (ovl) begin
            fst   <= ST_OVERLAP;
            state <= S_F_RET;
          end else if (mprev) begin
            fst   <= ST_OK;
            state <= mnext ? S_F_MRG2 : S_F_RET;
          end else if (mnext) begin
            fst   <= ST_OK;
            state <= S_F_RET;
          end else if (count >= IW'(DEPTH)) begin
            fst   <= ST_FULL;
            state <= S_F_RET;
          end else begin
            sh    <= count;
            state <= S_F_SHUP;
          end
        end
        S_F_MRG2: begin
          sh         <= j;
          dctx_alloc <= 1'b0;
          state      <= S_DROP;
        end
        S_F_SHUP: begin
          if (sh == j) begin
            count <= count + IW'(1);
            fst   <= ST_OK;
            state <= S_F_RET;
          end else begin
            state <= S_F_SHUPW;
          end
        end
        S_F_SHUPW: begin
          sh    <= sh - IW'(1);
          state <= S_F_SHUP;
        end
        // ---------------- remove entry sh ----------------
        S_DROP: begin
          if (sh + IW'(1) == count) begin
            count <= count - IW'(1);
            fst   <= ST_OK;
            state <= dctx_alloc ? S_A_REM : S_F_RET;
          end else begin
            state <= S_DROPW;
          end
        end
        S_DROPW: begin
          sh    <= sh + IW'(1);
          state <= S_DROP;
        end
        // ---------------- free return ----------------
        S_F_RET: begin
          unique case (fctx)
            FC_CMD: begin
              res_st <= fst;
              state  <= S_DONE;
            end
            FC_AREM: begin
              state <= S_A_OK;
            end
            FC_ITYP: begin
              if (fst != ST_OK) begin
                sv_st <= fst;
                fa    <= addr;
                fs    <= len;
                fk    <= KindNone;
                fctx  <= FC_IUNDO;
                state <= S_F_START;
              end else begin
                res_st <= ST_OK;
                state  <= S_DONE;
              end
            end
            FC_IUNDO: begin
              res_st <= sv_st;
              state  <= S_DONE;
            end
          endcase
        end
        // ---------------- alloc ----------------
        S_A_RD: begin
          state <= (j == count) ? S_A_FAIL : S_A_EV;
        end
        S_A_EV: begin
          cur  <= rd;
          cend <= rd.start + rd.len;
          aa   <= (addr != '0) ? addr : rd.start;
          if (rd.kind != akind) begin
            j     <= j + IW'(1);
            state <= S_A_RD;
          end else if ((addr != '0) && (rd.start > addr)) begin
            state <= S_A_FAIL;
          end else if ((addr != '0) && (rd.len < diff)) begin
            j     <= j + IW'(1);
            state <= S_A_RD;
          end else if ((addr != '0) && (diff > lmsub)) begin
            state <= S_A_FAIL;
          end else begin
            state <= (al != '0) ? S_A_DSET : S_A_FIT;
          end
        end
        S_A_DSET: begin
          tq    <= aa + AddrWidth'(al) - AddrWidth'(1);
          dq    <= aa + AddrWidth'(al) - AddrWidth'(1);
          rem   <= '0;
          dcnt  <= '0;
          state <= S_A_DIV;
        end
        S_A_DIV: begin
          // one restoring remainder step per cycle
          if (dcnt == SW'(DivSteps)) begin
            aa    <= tq - AddrWidth'(rem);
            state <= S_A_FIT;
          end else begin
            rem  <= (rs >= {1'b0, al}) ? AlignWidth'(rs - {1'b0, al})
                                       : AlignWidth'(rs);
            dq   <= dq << 1;
            dcnt <= dcnt + SW'(1);
          end
        end
        S_A_FIT: begin
          fd <= cend - aa;
          if ((cend - aa) < len) begin
            j     <= j + IW'(1);
            state <= S_A_RD;
          end else begin
            state <= S_A_CUT;
          end
        end
        S_A_CUT: begin
          if (nl == '0) begin
            sh         <= j;
            dctx_alloc <= 1'b1;
            state      <= S_DROP;
          end else begin
            state <= S_A_REM;
          end
        end
        S_A_REM: begin
          if (cur.start != aa) begin
            fa    <= cur.start;
            fs    <= aa - cur.start;
            fk    <= akind;
            fctx  <= FC_AREM;
            state <= S_F_START;
          end else begin
            state <= S_A_OK;
          end
        end
        S_A_OK: begin
          if (cmd == CMD_ALLOC) begin
            res_st  <= ST_OK;
            res_got <= aa;
            state   <= S_DONE;
          end else begin
            fa    <= addr;
            fs    <= len;
            fk    <= kind;
            fctx  <= FC_ITYP;
            state <= S_F_START;
          end
        end
        S_A_FAIL: begin
          res_st  <= ST_NOFIT;
          res_got <= '0;
          state   <= S_DONE;
        end
        // ---------------- hand off the result beat ----------------
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            status          <= res_st;
            granted_address <= res_got;
            result_valid    <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
